[hdl/pcb_pkg.sv]
// ----------------------------------------------------------------------------
// pcb_pkg
// shared constants, command and status types and the segment decoder of the
// presence counter with baseline
// ----------------------------------------------------------------------------
`default_nettype none

package pcb_pkg;

   // parameter defaults
   localparam int DIST_BITS_DEF  = 10;
   localparam int MAX_CALIB_DEF  = 16;
   localparam int COUNT_BITS_DEF = 16;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR  = 3'd4;

   // register reset values
   localparam logic [9:0] MARGIN_RESET = 10'd20;
   localparam logic [9:0] MIN_RESET    = 10'd5;
   localparam logic [9:0] MAX_RESET    = 10'd300;
   localparam logic [4:0] CALIB_RESET  = 5'd10;
   localparam logic [2:0] CLEAR_RESET  = 3'd3;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic eval;
      logic div_step;
      logic base_load;
      logic conv_start;
      logic conv_step;
      logic out_load;
   } pcb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic calib_ok;
   } pcb_status_type;

   // seven-segment code, bit0 is segment a
   function automatic logic [6:0] seg_code(input logic [3:0] digit);
      logic [6:0] code;
      case (digit)
         4'd0:    code = 7'h3F;
         4'd1:    code = 7'h06;
         4'd2:    code = 7'h5B;
         4'd3:    code = 7'h4F;
         4'd4:    code = 7'h66;
         4'd5:    code = 7'h6D;
         4'd6:    code = 7'h7D;
         4'd7:    code = 7'h07;
         4'd8:    code = 7'h7F;
         4'd9:    code = 7'h6F;
         default: code = 7'h00;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

[hdl/pcb_ctrl.sv]
// ----------------------------------------------------------------------------
// pcb_ctrl
// sequencer: sample capture, evaluation, baseline division, digit conversion
// and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module pcb_ctrl
   import pcb_pkg::*;
#(
   parameter int DIV_STEPS  = 14,
   parameter int CONV_STEPS = 16
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output pcb_cmd_type         cmd,
   input  wire pcb_status_type status
);

   localparam int MAX_STEPS = (DIV_STEPS > CONV_STEPS) ? DIV_STEPS : CONV_STEPS;
   localparam int STEP_W    = (MAX_STEPS > 2) ? $clog2(MAX_STEPS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_BASE,
      ST_CONV_INIT,
      ST_CONV,
      ST_LOAD
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            step_in  = '0;
            state_in = status.calib_ok ? ST_DIV : ST_CONV_INIT;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            cmd.base_load = 1'b1;
            state_in      = ST_CONV_INIT;
         end
         ST_CONV_INIT: begin
            cmd.conv_start = 1'b1;
            step_in        = '0;
            state_in       = ST_CONV;
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == STEP_W'(CONV_STEPS - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // an accepted sample is evaluated in the next cycle
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EVAL))
      else $error("accepted sample not evaluated");

   // the result register is never overwritten while it still waits
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");

   // a load always presents a result
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("loaded result not presented");

   // datapath steps never overlap
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.eval, cmd.div_step, cmd.base_load, cmd.conv_start,
                cmd.conv_step, cmd.out_load}))
      else $error("overlapping datapath commands");

endmodule

`default_nettype wire

[hdl/pcb_datapath.sv]
// ----------------------------------------------------------------------------
// pcb_datapath
// configuration registers, phase and counter state, restoring divider for the
// baseline, double-dabble digit split and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module pcb_datapath
   import pcb_pkg::*;
#(
   parameter int DIST_BITS  = DIST_BITS_DEF,
   parameter int MAX_CALIB  = MAX_CALIB_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pcb_cmd_type           cmd,
   output pcb_status_type             status,
   input  wire logic [DIST_BITS-1:0]  req_distance_cm,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output logic [1:0]                 rsp_phase,
   output logic                       rsp_present,
   output logic [15:0]                rsp_people,
   output logic [9:0]                 rsp_ref_level,
   output logic [6:0]                 rsp_seg_thousands,
   output logic [6:0]                 rsp_seg_hundreds,
   output logic [6:0]                 rsp_seg_tens,
   output logic [6:0]                 rsp_seg_ones
);

   localparam int CNT_W = $clog2(MAX_CALIB + 1);
   localparam int SUM_W = DIST_BITS + CNT_W;
   localparam int CMP_W = ((DIST_BITS > 10) ? DIST_BITS : 10) + 1;
   localparam int TOT_W = (CNT_W > 5) ? CNT_W : 5;
   localparam int PPL_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam int REF_W = (DIST_BITS > 10) ? DIST_BITS : 10;

   typedef enum logic [1:0] {
      PH_CAL   = 2'd0,
      PH_IDLE  = 2'd1,
      PH_OCC   = 2'd2,
      PH_FAULT = 2'd3
   } phase_type;

   // configuration
   logic [9:0] margin_ff, min_ff, max_ff;
   logic [4:0] calib_ff;
   logic [2:0] clear_ff;

   // state
   phase_type             phase_ff, phase_in;
   logic [CNT_W-1:0]      seen_ff, seen_in;
   logic [CNT_W-1:0]      good_ff, good_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [DIST_BITS-1:0]  base_ff;
   logic [2:0]            run_ff, run_in;
   logic [COUNT_BITS-1:0] people_ff, people_in;
   logic                  calib_ok;

   // work registers
   logic [DIST_BITS-1:0]  dist_ff;
   logic [SUM_W-1:0]      quo_ff;
   logic [CNT_W-1:0]      rem_ff;
   logic [COUNT_BITS-1:0] csh_ff;
   logic [15:0]           bcd_ff;

   // sample classification
   logic [CMP_W-1:0] dist_ext, close_sum;
   logic             sample_ok, sample_close;
   logic [TOT_W-1:0] total_wide;
   logic [CNT_W-1:0] total;
   logic [2:0]       need, run_next;

   assign dist_ext     = CMP_W'(dist_ff);
   assign close_sum    = dist_ext + CMP_W'(margin_ff);
   assign sample_ok    = (dist_ext >= CMP_W'(min_ff)) && (dist_ext <= CMP_W'(max_ff));
   assign sample_close = close_sum < CMP_W'(base_ff);
   assign need         = (clear_ff == 3'd0) ? 3'd1 : clear_ff;
   assign run_next     = run_ff + 3'd1;

   always_comb begin
      if (calib_ff == 5'd0) begin
         total_wide = TOT_W'(1);
      end else if (TOT_W'(calib_ff) > TOT_W'(MAX_CALIB)) begin
         total_wide = TOT_W'(MAX_CALIB);
      end else begin
         total_wide = TOT_W'(calib_ff);
      end
   end
   assign total = total_wide[CNT_W-1:0];

   always_comb begin
      phase_in  = phase_ff;
      seen_in   = seen_ff;
      good_in   = good_ff;
      sum_in    = sum_ff;
      run_in    = run_ff;
      people_in = people_ff;
      calib_ok  = 1'b0;
      case (phase_ff)
         PH_CAL: begin
            if (sample_ok) begin
               sum_in  = sum_ff + SUM_W'(dist_ff);
               good_in = good_ff + 1'b1;
            end
            seen_in = seen_ff + 1'b1;
            if (seen_in >= total) begin
               if ((good_in != '0) && (good_in >= (total >> 1))) begin
                  phase_in = PH_IDLE;
                  calib_ok = 1'b1;
               end else begin
                  phase_in = PH_FAULT;
               end
            end
         end
         PH_IDLE: begin
            if (sample_ok && sample_close) begin
               people_in = people_ff + 1'b1;
               run_in    = 3'd0;
               phase_in  = PH_OCC;
            end
         end
         PH_OCC: begin
            if (sample_ok) begin
               if (!sample_close) begin
                  if (run_next >= need) begin
                     run_in   = 3'd0;
                     phase_in = PH_IDLE;
                  end else begin
                     run_in = run_next;
                  end
               end else begin
                  run_in = 3'd0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign status.calib_ok = calib_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
         min_ff    <= MIN_RESET;
         max_ff    <= MAX_RESET;
         calib_ff  <= CALIB_RESET;
         clear_ff  <= CLEAR_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MARGIN: margin_ff <= csr_data[9:0];
            CSR_MIN:    min_ff    <= csr_data[9:0];
            CSR_MAX:    max_ff    <= csr_data[9:0];
            CSR_CALIB:  calib_ff  <= csr_data[4:0];
            CSR_CLEAR:  clear_ff  <= csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_CAL;
         seen_ff   <= '0;
         good_ff   <= '0;
         sum_ff    <= '0;
         base_ff   <= '0;
         run_ff    <= '0;
         people_ff <= '0;
      end else begin
         if (cmd.eval) begin
            phase_ff  <= phase_in;
            seen_ff   <= seen_in;
            good_ff   <= good_in;
            sum_ff    <= sum_in;
            run_ff    <= run_in;
            people_ff <= people_in;
         end
         if (cmd.base_load) begin
            base_ff <= quo_ff[DIST_BITS-1:0];
         end
      end
   end

   // restoring divider, one quotient bit per step
   logic [CNT_W:0] rem_sh, rem_sub;
   logic           rem_ge;

   assign rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_ge  = rem_sh >= {1'b0, good_ff};
   assign rem_sub = rem_sh - {1'b0, good_ff};

   // binary to bcd, four digits kept so the result is modulo 10000
   logic [15:0] bcd_adj;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ?
                             (bcd_ff[4*i +: 4] + 4'd3) : bcd_ff[4*i +: 4];
      end
   end

   logic [PPL_W-1:0] people_ext;
   logic [REF_W-1:0] base_ext;

   assign people_ext = PPL_W'(people_ff);
   assign base_ext   = REF_W'(base_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dist_ff <= req_distance_cm;
      end
      if (cmd.eval) begin
         quo_ff <= sum_in;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[SUM_W-2:0], rem_ge};
         rem_ff <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      end
      if (cmd.conv_start) begin
         csh_ff <= people_ff;
         bcd_ff <= '0;
      end else if (cmd.conv_step) begin
         csh_ff <= csh_ff << 1;
         bcd_ff <= {bcd_adj[14:0], csh_ff[COUNT_BITS-1]};
      end
      if (cmd.out_load) begin
         rsp_phase         <= phase_ff;
         rsp_present       <= (phase_ff == PH_OCC);
         rsp_people        <= people_ext[15:0];
         rsp_ref_level     <= ((phase_ff == PH_IDLE) || (phase_ff == PH_OCC)) ?
                              base_ext[9:0] : 10'd0;
         rsp_seg_thousands <= seg_code(bcd_ff[15:12]);
         rsp_seg_hundreds  <= seg_code(bcd_ff[11:8]);
         rsp_seg_tens      <= seg_code(bcd_ff[7:4]);
         rsp_seg_ones      <= seg_code(bcd_ff[3:0]);
      end
   end

endmodule

`default_nettype wire

[hdl/presence_counter_with_baseline_top.sv]
// ----------------------------------------------------------------------------
// presence_counter_with_baseline_top
// distance-based people counter: calibrates a baseline distance, then counts
// each approach closer than baseline minus margin, with seven-segment digits
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_distance_cm
//   rsp      out  rsp_valid/rsp_ready    phase, present, people, ref_level, segs
//   csr      in   csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// one sample in flight; each sample runs the bit-serial bcd conversion of the
// count, and the sample that completes calibration successfully also runs the
// restoring divider over every bit of the calibration sum before the conversion
// reset is synchronous; no clearing pass, the block takes samples at once
// the finished result sits in an output register, so the next sample is
// taken while rsp is stalled; only the final load waits for rsp_ready
// ----------------------------------------------------------------------------
`default_nettype none

module presence_counter_with_baseline_top
   import pcb_pkg::*;
#(
   parameter int DIST_BITS  = DIST_BITS_DEF,
   parameter int MAX_CALIB  = MAX_CALIB_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // sample beat
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [DIST_BITS-1:0]  req_distance_cm,
   // result beat
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_phase,
   output logic                       rsp_present,
   output logic [15:0]                rsp_people,
   output logic [9:0]                 rsp_ref_level,
   output logic [6:0]                 rsp_seg_thousands,
   output logic [6:0]                 rsp_seg_hundreds,
   output logic [6:0]                 rsp_seg_tens,
   output logic [6:0]                 rsp_seg_ones,
   // register write beat
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // divider runs one step per bit of the calibration sum
   localparam int DIV_STEPS = DIST_BITS + $clog2(MAX_CALIB + 1);

   pcb_cmd_type    cmd;
   pcb_status_type status;

   // register writes are taken in any cycle
   assign csr_ready = 1'b1;

   // sequencer
   pcb_ctrl #(
      .DIV_STEPS  (DIV_STEPS),
      .CONV_STEPS (COUNT_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // state, arithmetic and result register
   pcb_datapath #(
      .DIST_BITS  (DIST_BITS),
      .MAX_CALIB  (MAX_CALIB),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_distance_cm   (req_distance_cm),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_phase         (rsp_phase),
      .rsp_present       (rsp_present),
      .rsp_people        (rsp_people),
      .rsp_ref_level     (rsp_ref_level),
      .rsp_seg_thousands (rsp_seg_thousands),
      .rsp_seg_hundreds  (rsp_seg_hundreds),
      .rsp_seg_tens      (rsp_seg_tens),
      .rsp_seg_ones      (rsp_seg_ones)
   );

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the presence counter with baseline: a clocked
// driver feeds distance beats from a queue, an in-bench predictor works out
// each expected reading, and a clocked monitor compares every rsp beat
// field by field against the oldest expected reading
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import pcb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // room states as the block reports them on rsp_phase
   typedef enum logic [1:0] {
      ROOM_CALIB = 2'd0,
      ROOM_EMPTY = 2'd1,
      ROOM_BUSY  = 2'd2,
      ROOM_FAULT = 2'd3
   } room_type;

   // one expected rsp beat
   typedef struct {
      logic [1:0]  phase;
      logic        present;
      logic [15:0] people;
      logic [9:0]  ref_level;
      logic [6:0]  seg_th;
      logic [6:0]  seg_hu;
      logic [6:0]  seg_te;
      logic [6:0]  seg_on;
   } reading_type;

   // one register write waiting to go out on csr
   typedef struct {
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] val;
   } reg_write_type;

   // digit glyphs, bit0 is segment a
   localparam logic [6:0] SEG_GLYPH [0:9] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   localparam int HOLD_CYCLES = 400;
   localparam int CHUNKS      = 13;
   localparam int CHUNK_ITEMS = 140;

   // clock, reset and dut ports; the ones driven here are known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [9:0]            req_distance_cm = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_phase;
   logic                  rsp_present;
   logic [15:0]           rsp_people;
   logic [9:0]            rsp_ref_level;
   logic [6:0]            rsp_seg_thousands;
   logic [6:0]            rsp_seg_hundreds;
   logic [6:0]            rsp_seg_tens;
   logic [6:0]            rsp_seg_ones;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // bench bookkeeping
   logic [9:0]     distances_pending[$];
   reading_type    readings_due[$];
   reg_write_type  writes_staged[$];
   int             items_taken = 0;
   int             results_seen = 0;
   int             mismatches = 0;
   int             hold_left = 0;
   int             last_hold = -1;

   // predictor copy of the registers, reset values
   int margin  = MARGIN_RESET;
   int lo_cm   = MIN_RESET;
   int hi_cm   = MAX_RESET;
   int cal_len = CALIB_RESET;
   int clr_len = CLEAR_RESET;

   // predictor copy of the state
   room_type    room = ROOM_CALIB;
   int          cal_seen = 0;
   int          cal_good = 0;
   int          cal_sum = 0;
   int          baseline = 0;
   int          clear_cnt = 0;
   logic [15:0] visitors = '0;

   presence_counter_with_baseline_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_distance_cm   (req_distance_cm),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_phase         (rsp_phase),
      .rsp_present       (rsp_present),
      .rsp_people        (rsp_people),
      .rsp_ref_level     (rsp_ref_level),
      .rsp_seg_thousands (rsp_seg_thousands),
      .rsp_seg_hundreds  (rsp_seg_hundreds),
      .rsp_seg_tens      (rsp_seg_tens),
      .rsp_seg_ones      (rsp_seg_ones),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // register write as the block sees it, field widths as in hardware
   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_MARGIN: margin  = val;
         CSR_MIN:    lo_cm   = val;
         CSR_MAX:    hi_cm   = val;
         CSR_CALIB:  cal_len = val[4:0];
         CSR_CLEAR:  clr_len = val[2:0];
         default: ;
      endcase
   endfunction

   // advance the room state by one distance beat and build the reading
   function automatic reading_type next_reading(input logic [9:0] d);
      reading_type r;
      int          sample_cm;
      int          span;
      int          need;
      int          shown;
      bit          ok;
      sample_cm = d;
      ok        = (sample_cm >= lo_cm) && (sample_cm <= hi_cm);
      case (room)
         ROOM_CALIB: begin
            // length clamped to 1..MAX_CALIB, checked on every beat
            span = (cal_len < 1) ? 1 : ((cal_len > MAX_CALIB_DEF) ? MAX_CALIB_DEF : cal_len);
            if (ok) begin
               cal_sum  += sample_cm;
               cal_good += 1;
            end
            cal_seen += 1;
            if (cal_seen >= span) begin
               // no good sample at all is a fault even when half rounds to zero
               if (cal_good != 0 && cal_good >= span / 2) begin
                  baseline = (cal_sum / cal_good) & 10'h3FF;
                  room     = ROOM_EMPTY;
               end else begin
                  room = ROOM_FAULT;
               end
            end
         end
         ROOM_EMPTY: begin
            if (ok && sample_cm + margin < baseline) begin
               visitors  = visitors + 16'd1;
               clear_cnt = 0;
               room      = ROOM_BUSY;
            end
         end
         ROOM_BUSY: begin
            if (ok) begin
               if (sample_cm + margin >= baseline) begin
                  need = (clr_len == 0) ? 1 : clr_len;
                  clear_cnt += 1;
                  if (clear_cnt >= need) begin
                     clear_cnt = 0;
                     room      = ROOM_EMPTY;
                  end
               end else begin
                  // a closer beat restarts the clear run
                  clear_cnt = 0;
               end
            end
         end
         default: ;
      endcase
      shown       = int'(visitors) % 10000;
      r.phase     = room;
      r.present   = (room == ROOM_BUSY);
      r.people    = visitors;
      r.ref_level = (room == ROOM_EMPTY || room == ROOM_BUSY) ? baseline[9:0] : 10'd0;
      r.seg_th    = SEG_GLYPH[(shown / 1000) % 10];
      r.seg_hu    = SEG_GLYPH[(shown / 100) % 10];
      r.seg_te    = SEG_GLYPH[(shown / 10) % 10];
      r.seg_on    = SEG_GLYPH[shown % 10];
      return r;
   endfunction

   // idle share in percent: sender light / receiver heavy, then swapped,
   // then no idling at all
   function automatic int gap_pct(input int done, input bit sender);
      if (done < 620) return sender ? 8 : 45;
      if (done < 1240) return sender ? 45 : 8;
      return 0;
   endfunction

   // driver: predicts on each accepted beat, then offers the next distance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            readings_due.push_back(next_reading(req_distance_cm));
            items_taken <= items_taken + 1;
         end
         if (!req_valid || req_ready) begin
            if (distances_pending.size() != 0 &&
                $urandom_range(99) >= gap_pct(items_taken, 1'b1)) begin
               req_valid       <= 1'b1;
               req_distance_cm <= distances_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here, so the block backs up onto req
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if ((results_seen == 370 || results_seen == 1450) &&
                   results_seen != last_hold) begin
         hold_left <= HOLD_CYCLES;
         last_hold <= results_seen;
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("reading %0d %s: expected %0d got %0d", results_seen, name, want, got);
      end
   endtask

   // monitor: every rsp beat against the oldest expected reading
   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (readings_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("reading %0d arrived with nothing expected", results_seen);
            end else begin
               want = readings_due.pop_front();
               check_field("phase", want.phase, rsp_phase);
               check_field("present", want.present, rsp_present);
               check_field("people", want.people, rsp_people);
               check_field("ref_level", want.ref_level, rsp_ref_level);
               check_field("seg_thousands", want.seg_th, rsp_seg_thousands);
               check_field("seg_hundreds", want.seg_hu, rsp_seg_hundreds);
               check_field("seg_tens", want.seg_te, rsp_seg_tens);
               check_field("seg_ones", want.seg_on, rsp_seg_ones);
            end
            results_seen <= results_seen + 1;
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= gap_pct(results_seen, 1'b0));
      end
   end

   function automatic void stage_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      reg_write_type w;
      w.idx = idx;
      w.val = val[CSR_DATA_W-1:0];
      writes_staged.push_back(w);
   endfunction

   // send the staged writes back to back on csr, valid held across beats
   task automatic write_staged();
      reg_write_type w;
      @(posedge clock);
      while (writes_staged.size() != 0) begin
         w = writes_staged.pop_front();
         csr_valid <= 1'b1;
         csr_index <= w.idx;
         csr_data  <= w.val;
         do @(posedge clock); while (!csr_ready);
         apply_reg(w.idx, w.val);
      end
      csr_valid <= 1'b0;
   endtask

   // sender pause: nothing queued, nothing offered, nothing outstanding
   task automatic wait_idle();
      do @(negedge clock);
      while (distances_pending.size() != 0 || req_valid || readings_due.size() != 0);
   endtask

   function automatic void offer(input int d);
      distances_pending.push_back(d[9:0]);
   endfunction

   // uniform pick in [lo, hi] clipped to the field, any distance if empty
   function automatic int pick(input int lo, input int hi);
      if (lo < 0) lo = 0;
      if (hi > 1023) hi = 1023;
      if (lo > hi) return $urandom_range(1023);
      return $urandom_range(hi, lo);
   endfunction

   // new random settings for a chunk, extremes now and then
   function automatic void shuffle_regs();
      stage_reg(CSR_MARGIN, ($urandom_range(99) < 10) ?
                ($urandom_range(1) ? 1023 : 0) : $urandom_range(60));
      stage_reg(CSR_MIN, ($urandom_range(99) < 10) ?
                ($urandom_range(1) ? 1023 : 0) : $urandom_range(30));
      stage_reg(CSR_MAX, ($urandom_range(99) < 10) ?
                ($urandom_range(1) ? 1023 : 0) : $urandom_range(1023, 200));
      stage_reg(CSR_CALIB, $urandom_range(1023));
      stage_reg(CSR_CLEAR, $urandom_range(1023));
   endfunction

   // mostly visits: one close beat then a run of mostly clear beats with
   // closer and out-of-window beats mixed in; the rest is plain noise
   function automatic void queue_traffic(input int count);
      int n;
      int k;
      int roll;
      int near_top;
      int clear_bot;
      n         = 0;
      near_top  = (baseline - margin - 1 < hi_cm) ? baseline - margin - 1 : hi_cm;
      clear_bot = (baseline - margin > lo_cm) ? baseline - margin : lo_cm;
      while (n < count) begin
         if ($urandom_range(99) < 15) begin
            offer($urandom_range(1023));
            n++;
         end else begin
            offer(pick(lo_cm, near_top));
            n++;
            k = $urandom_range(clr_len + 2);
            repeat (k) begin
               roll = $urandom_range(99);
               if (roll < 70) offer(pick(clear_bot, hi_cm));
               else if (roll < 85) offer(pick(lo_cm, near_top));
               else offer($urandom_range(1023));
               n++;
            end
         end
      end
   endfunction

   // stimulus
   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // calibration length far above the maximum, so it acts as the maximum
      stage_reg(CSR_CALIB, 1023);
      stage_reg(CSR_MIN, 10);
      stage_reg(CSR_MAX, 400);
      write_staged();
      // no echo, top of field, below and above the window, three good ones
      offer(0); offer(1023); offer(200); offer(220); offer(9); offer(410); offer(240);
      wait_idle();

      // length lowered mid-way to zero, which acts as one: next beat ends it
      stage_reg(CSR_CALIB, 0);
      write_staged();
      offer(260);
      wait_idle();

      // zero margin, zero clear run (acts as one), widest window
      stage_reg(CSR_MARGIN, 0);
      stage_reg(CSR_CLEAR, 0);
      stage_reg(CSR_MIN, 0);
      stage_reg(CSR_MAX, 1023);
      write_staged();
      offer(230); offer(229); offer(0); offer(1023); offer(0); offer(230);
      wait_idle();

      // largest margin: nothing can count
      stage_reg(CSR_MARGIN, 1023);
      stage_reg(CSR_CLEAR, 7);
      write_staged();
      offer(0); offer(1023);
      wait_idle();

      // inverted window: every beat is ignored
      stage_reg(CSR_MARGIN, 229);
      stage_reg(CSR_MIN, 1023);
      stage_reg(CSR_MAX, 0);
      write_staged();
      offer(0); offer(500);
      wait_idle();

      // occupied: ignored beats, a closer beat restarting the clear run
      stage_reg(CSR_MARGIN, 20);
      stage_reg(CSR_MIN, 5);
      stage_reg(CSR_MAX, 300);
      stage_reg(CSR_CLEAR, 2);
      write_staged();
      offer(100); offer(4); offer(301); offer(250); offer(100); offer(250); offer(250);
      wait_idle();

      // random chunks, each under fresh settings
      for (int c = 0; c < CHUNKS; c++) begin
         shuffle_regs();
         write_staged();
         queue_traffic(CHUNK_ITEMS);
         wait_idle();
      end

      // let any stray beat show up before the verdict
      repeat (40) @(posedge clock);
      if (mismatches == 0 && readings_due.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #8_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
